/* sv/swr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swr_pkg
// Shared widths, register map and controller states of the sliding-window
// RMS level detector.
// ----------------------------------------------------------------------------
package swr_pkg;

   localparam int SAMPLE_W           = 16;   // Q1.15 sample
   localparam int SQ_W               = 31;   // square of a sample, at most 2^30
   localparam int SUM_W              = 41;   // sum of squares over the window
   localparam int LEN_W              = 11;   // window_length register
   localparam int LEN_RESET          = 1024;
   localparam int RMS_W              = 16;
   localparam int MEAN_W             = 32;   // mean of squares, at most 2^30
   localparam int REM_W              = 19;   // root remainder
   localparam int DIV_STEPS          = SUM_W;
   localparam int ROOT_STEPS         = MEAN_W / 2;
   localparam int STEP_W             = 6;
   localparam int MAX_WINDOW_DEFAULT = 1024;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [0:0] {
      REG_WINDOW_LENGTH = 1'b0
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OLD,
      ST_SUM,
      ST_DIV,
      ST_ROOT,
      ST_DONE
   } state_type;

endpackage

/* sv/swr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/sliding_window_rms.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_rms
// Moving-window RMS level detector for Q1.15 audio samples.
// ----------------------------------------------------------------------------
// Each req item carries one signed Q1.15 sample; it replaces the oldest of the
// last window_length samples held in a ring memory, a running sum of squares
// is updated, and one rsp item returns floor(sqrt(sum / window_length)) as a
// Q1.15 RMS level together with the oldest sample still in the window. Each
// item passes through a ring read and squaring, a sum update, a bit-serial
// divider and a bit-serial square root; a new item is taken only once the
// last one has left the datapath. Results wait in an output register, so the
// next item is taken while a result is still pending. Writing window_length
// (only while idle) clears the window to zeros at once; a fill count stands
// in for a clearing pass, so there is no dead time after reset or a write.
// Lengths of zero read as one and lengths above MAX_WINDOW saturate.
// ----------------------------------------------------------------------------
module sliding_window_rms #(
   parameter int MAX_WINDOW = swr_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // input stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [15:0]                    req_tdata,    // [15:0] sample
   // result stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [31:0]                    rsp_tdata,    // [15:0] rms_level, [31:16] oldest_sample
   // configuration
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [swr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [swr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [swr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   localparam int ADDR_W    = $clog2(MAX_WINDOW);
   localparam int MAX_LEN   = (MAX_WINDOW < 2047) ? MAX_WINDOW : 2047;
   localparam int RESET_LEN = (swr_pkg::LEN_RESET > MAX_WINDOW) ?
                              MAX_WINDOW : swr_pkg::LEN_RESET;

   // ------------------------------------------------------------------
   // configuration
   // ------------------------------------------------------------------
   logic                       cfg_wr;
   logic [swr_pkg::LEN_W-1:0]  wr_len;
   logic [swr_pkg::LEN_W-1:0]  len_ff;
   logic [swr_pkg::LEN_W-1:0]  len_in;

   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == swr_pkg::REG_WINDOW_LENGTH);
   assign wr_len = csr_pwdata[swr_pkg::LEN_W-1:0];

   always_comb begin
      priority if (wr_len == '0) begin
         len_in = swr_pkg::LEN_W'(1);
      end else if (32'(wr_len) > 32'(MAX_WINDOW)) begin
         len_in = swr_pkg::LEN_W'(MAX_LEN);
      end else begin
         len_in = wr_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= swr_pkg::LEN_W'(RESET_LEN);
      end else if (cfg_wr) begin
         len_ff <= len_in;
      end
   end

   always_comb begin
      if (csr_paddr[2] == swr_pkg::REG_WINDOW_LENGTH) begin
         csr_prdata = {{(swr_pkg::CSR_DATA_W - swr_pkg::LEN_W){1'b0}}, len_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   // ------------------------------------------------------------------
   // datapath registers
   // ------------------------------------------------------------------
   swr_pkg::state_type             state_ff, state_in;
   logic [swr_pkg::STEP_W-1:0]     step_ff, step_in;
   logic [ADDR_W-1:0]              pos_ff, pos_in, pos_next;
   logic [swr_pkg::LEN_W-1:0]      fill_ff, fill_in;
   logic [swr_pkg::SUM_W-1:0]      sum_ff, sum_in;
   logic [swr_pkg::SAMPLE_W-1:0]   sample_ff;
   logic [swr_pkg::SQ_W-1:0]       new_sq_ff, old_sq_ff;
   logic                           old_fwd_ff, old_valid_ff;
   logic [swr_pkg::SAMPLE_W-1:0]   oldest_ff, oldest_in;
   logic [swr_pkg::SUM_W-1:0]      dvd_ff, dvd_in;
   logic [swr_pkg::LEN_W-1:0]      drem_ff, drem_in;
   logic [swr_pkg::MEAN_W-1:0]     src_ff, src_in;
   logic [swr_pkg::REM_W-1:0]      rrem_ff, rrem_in;
   logic [swr_pkg::RMS_W-1:0]      root_ff, root_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [swr_pkg::RMS_W-1:0]      rsp_rms_ff;
   logic [swr_pkg::SAMPLE_W-1:0]   rsp_oldest_ff;

   logic                           accept;
   logic                           load_rsp;
   logic                           old_valid;
   logic [swr_pkg::SAMPLE_W-1:0]   old_sample;
   logic signed [31:0]             new_prod, old_prod;
   logic [swr_pkg::LEN_W:0]        div_sh;
   logic                           div_ge;
   logic [swr_pkg::REM_W-1:0]      root_sh, root_trial;
   logic                           root_ge;

   // ring memory
   logic                           ram_wr;
   logic [ADDR_W-1:0]              ram_rd_addr;
   logic [swr_pkg::SAMPLE_W-1:0]   ram_rd_data;

   swr_ram #(
      .WIDTH (swr_pkg::SAMPLE_W),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (pos_ff),
      .wr_data (sample_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_tready = (state_ff == swr_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign pos_next = (32'(pos_ff) + 32'd1 >= 32'(len_ff)) ? '0 : pos_ff + 1'b1;
   assign old_valid = (32'(pos_ff) < 32'(fill_ff));
   assign old_sample = old_valid ? ram_rd_data : '0;

   assign new_prod = $signed(req_tdata) * $signed(req_tdata);
   assign old_prod = $signed(old_sample) * $signed(old_sample);

   // divider step
   assign div_sh = {drem_ff, dvd_ff[swr_pkg::SUM_W-1]};
   assign div_ge = (div_sh >= {1'b0, len_ff});

   // square root step
   assign root_sh    = {rrem_ff[swr_pkg::REM_W-3:0], src_ff[swr_pkg::MEAN_W-1 -: 2]};
   assign root_trial = swr_pkg::REM_W'({root_ff, 2'b01});
   assign root_ge    = (root_sh >= root_trial);

   assign load_rsp = (state_ff == swr_pkg::ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swr_pkg::ST_IDLE;
         step_ff      <= '0;
         pos_ff       <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         pos_ff       <= pos_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_tdata;
         new_sq_ff <= new_prod[swr_pkg::SQ_W-1:0];
      end
      if (state_ff == swr_pkg::ST_OLD) begin
         old_sq_ff    <= old_prod[swr_pkg::SQ_W-1:0];
         old_fwd_ff   <= (pos_next == pos_ff);
         old_valid_ff <= (32'(pos_next) < 32'(fill_ff));
      end
      oldest_ff <= oldest_in;
      dvd_ff    <= dvd_in;
      drem_ff   <= drem_in;
      src_ff    <= src_in;
      rrem_ff   <= rrem_in;
      root_ff   <= root_in;
      if (load_rsp) begin
         rsp_rms_ff    <= root_ff;
         rsp_oldest_ff <= oldest_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      pos_in       = pos_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      oldest_in    = oldest_ff;
      dvd_in       = dvd_ff;
      drem_in      = drem_ff;
      src_in       = src_ff;
      rrem_in      = rrem_ff;
      root_in      = root_ff;
      ram_wr       = 1'b0;
      ram_rd_addr  = pos_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         swr_pkg::ST_IDLE: begin
            // clear the window on a length write
            if (cfg_wr) begin
               pos_in  = '0;
               fill_in = '0;
               sum_in  = '0;
            end
            if (accept) begin
               state_in = swr_pkg::ST_OLD;
            end
         end
         swr_pkg::ST_OLD: begin
            // overwritten entry is on the read port; fetch the next oldest
            ram_rd_addr = pos_next;
            ram_wr      = 1'b1;
            pos_in      = pos_next;
            if (fill_ff < len_ff) begin
               fill_in = fill_ff + 1'b1;
            end
            state_in = swr_pkg::ST_SUM;
         end
         swr_pkg::ST_SUM: begin
            sum_in = sum_ff - swr_pkg::SUM_W'(old_sq_ff) + swr_pkg::SUM_W'(new_sq_ff);
            priority if (old_fwd_ff) begin
               oldest_in = sample_ff;
            end else if (old_valid_ff) begin
               oldest_in = ram_rd_data;
            end else begin
               oldest_in = '0;
            end
            step_in  = '0;
            state_in = swr_pkg::ST_DIV;
            dvd_in   = sum_in;
            drem_in  = '0;
         end
         swr_pkg::ST_DIV: begin
            dvd_in = {dvd_ff[swr_pkg::SUM_W-2:0], div_ge};
            if (div_ge) begin
               drem_in = swr_pkg::LEN_W'(div_sh - {1'b0, len_ff});
            end else begin
               drem_in = div_sh[swr_pkg::LEN_W-1:0];
            end
            if (step_ff == swr_pkg::STEP_W'(swr_pkg::DIV_STEPS - 1)) begin
               step_in  = '0;
               state_in = swr_pkg::ST_ROOT;
               src_in   = dvd_in[swr_pkg::MEAN_W-1:0];
               rrem_in  = '0;
               root_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         swr_pkg::ST_ROOT: begin
            src_in = {src_ff[swr_pkg::MEAN_W-3:0], 2'b00};
            if (root_ge) begin
               rrem_in = root_sh - root_trial;
               root_in = {root_ff[swr_pkg::RMS_W-2:0], 1'b1};
            end else begin
               rrem_in = root_sh;
               root_in = {root_ff[swr_pkg::RMS_W-2:0], 1'b0};
            end
            if (step_ff == swr_pkg::STEP_W'(swr_pkg::ROOT_STEPS - 1)) begin
               step_in  = '0;
               state_in = swr_pkg::ST_DONE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         swr_pkg::ST_DONE: begin
            // hold until the output register is free
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               state_in     = swr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swr_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_oldest_ff, rsp_rms_ff};

endmodule

/* test/swr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swr_checker
// Watches the sample, level and register channels of sliding_window_rms.
// ----------------------------------------------------------------------------
// Keeps its own copy of the sample window and running energy. Every accepted
// sample is folded into that window to work out the RMS level and oldest
// sample that the block must return. Each returned item is compared field by
// field with the oldest prediction. Register writes seen on the csr port
// re-size and clear the local window just as they do in the block.
// ----------------------------------------------------------------------------
module swr_checker
   import swr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [15:0]           req_tdata,    // [15:0] sample
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [31:0]           rsp_tdata,    // [15:0] rms_level, [31:16] oldest_sample
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    mismatch_count,
   output int                    outstanding
);

   localparam int WINDOW_DEPTH = MAX_WINDOW_DEFAULT;
   localparam logic [CSR_ADDR_W-1:0] LENGTH_ADDR =
      CSR_ADDR_W'(4 * int'(REG_WINDOW_LENGTH));

   typedef struct packed {
      logic [15:0] oldest_sample;
      logic [15:0] rms_level;
   } level_t;

   logic [15:0]     ring [WINDOW_DEPTH];
   int unsigned     head;
   int unsigned     span;
   longint unsigned energy;
   level_t          pending_levels [$];

   function automatic int unsigned clamp_span(input logic [LEN_W-1:0] value);
      if (value == 0)
         return 1;
      if (value > WINDOW_DEPTH)
         return WINDOW_DEPTH;
      return value;
   endfunction

   function automatic longint unsigned square(input logic [15:0] s);
      longint v;
      v = longint'($signed(s));
      return v * v;
   endfunction

   function automatic longint unsigned floor_root(input longint unsigned x);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= x)
            root = trial;
      end
      return root;
   endfunction

   task automatic clear_window();
      foreach (ring[i])
         ring[i] = '0;
      head   = 0;
      energy = 0;
   endtask

   // replace the oldest entry and work out the level over the window
   task automatic slide_window(input logic [15:0] s, output level_t level);
      longint unsigned mean;
      energy     = energy - square(ring[head]) + square(s);
      ring[head] = s;
      head       = (head + 1 >= span) ? 0 : head + 1;
      mean       = energy / span;
      level.rms_level     = 16'(floor_root(mean));
      level.oldest_sample = ring[head];
   endtask

   always @(posedge clock) begin
      level_t want;
      level_t got;
      level_t fresh;
      if (reset) begin
         span = clamp_span(LEN_W'(LEN_RESET));
         clear_window();
         pending_levels.delete();
         mismatch_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == LENGTH_ADDR) begin
            span = clamp_span(csr_pwdata[LEN_W-1:0]);
            clear_window();
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pending_levels.size() == 0) begin
               $error("unexpected item: rms_level %0d oldest_sample %0d",
                      got.rms_level, $signed(got.oldest_sample));
               mismatch_count++;
            end else begin
               want = pending_levels.pop_front();
               if (got.rms_level !== want.rms_level) begin
                  $error("rms_level: expected %0d, actual %0d",
                         want.rms_level, got.rms_level);
                  mismatch_count++;
               end
               if (got.oldest_sample !== want.oldest_sample) begin
                  $error("oldest_sample: expected %0d, actual %0d",
                         $signed(want.oldest_sample), $signed(got.oldest_sample));
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            slide_window(req_tdata, fresh);
            pending_levels.push_back(fresh);
         end
      end
      outstanding = pending_levels.size();
   end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the sliding-window RMS level detector.
// ----------------------------------------------------------------------------
// Feeds directed extremes, then random phases at many window lengths,
// including zero, one and lengths past the maximum. Both streams idle at
// random, and in the last phase the level side holds off for a long stretch
// so that the block backs up. Checking is done by swr_checker.
// ----------------------------------------------------------------------------
module tb_top;
   import swr_pkg::*;

   localparam int CLOCK_LIMIT  = 1_000_000;
   localparam int HOLD_CYCLES  = 1500;
   localparam int DRAIN_CYCLES = 80;
   localparam int GAP_MAX      = 12;
   localparam logic [CSR_ADDR_W-1:0] LENGTH_ADDR =
      CSR_ADDR_W'(4 * int'(REG_WINDOW_LENGTH));
   // first address past the register map
   localparam logic [CSR_ADDR_W-1:0] UNMAPPED_ADDR =
      CSR_ADDR_W'(4 * (int'(REG_WINDOW_LENGTH) + 1));

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [15:0]           req_tdata;    // [15:0] sample
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [31:0]           rsp_tdata;    // [15:0] rms_level, [31:16] oldest_sample
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int mismatch_count;
   int outstanding;
   int cycle_count = 0;
   int req_gap_max = GAP_MAX;
   int rsp_gap_max = GAP_MAX;
   bit hold_pending = 0;

   sliding_window_rms u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   swr_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CLOCK_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // level side: random stalls, plus one long hold-off when asked
   initial begin
      int gap;
      bit held;
      held       = 0;
      rsp_tready = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         if (hold_pending && !held) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            held = 1;
         end
         gap = $urandom_range(0, rsp_gap_max);
         repeat (gap) begin
            rsp_tready <= 1'b0;
            @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   task automatic send_sample(input logic [15:0] s);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      repeat (gap) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 16'($urandom);
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      @(negedge clock);
   endtask

   // drop valid and wait for every level to come back
   task automatic settle();
      req_tvalid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_ADDR_W-1:0] addr,
                                 input logic [CSR_DATA_W-1:0] value);
      settle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      // leave the bus idle between transfers
      @(negedge clock);
   endtask

   function automatic logic [15:0] draw_sample(input int amplitude);
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2, 3:    return 16'($signed($urandom_range(0, 16)) - 8);
         4, 5:    return $urandom_range(0, 1) ? 16'(amplitude) : 16'(-amplitude);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic int unsigned pick_length(input int phase);
      case (phase)
         0:       return 1;
         1:       return 2;
         2:       return 0;
         3:       return 2047;
         4:       return 1024;
         5:       return 3;
         default: return $urandom_range(0, 3) != 0 ? $urandom_range(4, 64)
                                                   : $urandom_range(0, 2047);
      endcase
   endfunction

   initial begin
      int unsigned span;
      int          count;
      int          amplitude;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes at the reset length
      send_sample(16'h8000);
      send_sample(16'h7FFF);
      send_sample(16'h0000);
      send_sample(16'hFFFF);
      send_sample(16'h0001);
      send_sample(16'h5555);
      send_sample(16'hAAAA);
      // length one: the level is the sample's magnitude, full scale reads 32768
      write_register(LENGTH_ADDR, 1);
      send_sample(16'h8000);
      send_sample(16'h7FFF);
      send_sample(16'hFFFF);
      // zero reads as one
      write_register(LENGTH_ADDR, 0);
      send_sample(16'h8000);
      send_sample(16'h1234);
      // rewriting the same value still clears the window
      write_register(LENGTH_ADDR, 2);
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      write_register(LENGTH_ADDR, 2);
      send_sample(16'h4000);
      send_sample(16'hC000);
      // lengths past the maximum saturate
      write_register(LENGTH_ADDR, 2047);
      send_sample(16'h7FFF);
      write_register(LENGTH_ADDR, 1025);
      send_sample(16'h8000);
      // unmapped address: ignored, window kept
      write_register(UNMAPPED_ADDR, 5);
      send_sample(16'h0100);
      send_sample(16'hFF00);

      // random phases at many lengths
      for (int phase = 0; phase < 13; phase++) begin
         span        = pick_length(phase);
         req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
         rsp_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
         amplitude   = $urandom_range(0, 32767);
         if (phase == 8)
            write_register(UNMAPPED_ADDR, 32'($urandom));
         write_register(LENGTH_ADDR, span | ($urandom & 32'hFFFF_F800));
         count = (span > 200) ? 60 : $urandom_range(40, 70);
         repeat (count)
            send_sample(draw_sample(amplitude));
      end

      // long run that wraps the ring, with a long hold-off on the level side
      req_gap_max = 0;
      rsp_gap_max = GAP_MAX;
      amplitude   = $urandom_range(0, 32767);
      write_register(LENGTH_ADDR, 300);
      hold_pending = 1;
      repeat (700)
         send_sample(draw_sample(amplitude));

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* files.f */
sv/swr_pkg.sv
sv/swr_ram.sv
sv/sliding_window_rms.sv
test/swr_checker.sv
test/tb_top.sv
